FILE: design/pas_pkg.sv
// shared constants and types for the packed array store
package pas_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int MODE_W = 2;
   localparam int IDX_W  = 4;
   localparam int STAT_W = 2;

   // packed stream widths, padded to whole bytes
   localparam int REQ_BITS = MODE_W + IDX_W + WORD_W;
   localparam int RSP_BITS = WORD_W + STAT_W + CNT_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND = 2'd0,
      MODE_GET    = 2'd1,
      MODE_UPDATE = 2'd2,
      MODE_REMOVE = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_ILLEGAL = 2'd1,
      STAT_FULL    = 2'd2
   } status_type;

   localparam logic [WORD_W-1:0] READ_ILLEGAL = '1;

endpackage

FILE: design/packed_array_store.sv
// packed array store: dense word array with append, get, update and remove
//
// Requests arrive on the req_ stream (mode, index, value) and each one gives
// exactly one response on the rsp_ stream (read_value, status, count).
// Append, update and every illegal request go from S_IDLE straight to S_DONE;
// a legal get passes through S_GET on the way.
// A legal remove moves every later element down one place through the single
// memory port pair, reading each element in S_SHRD and writing it one place
// lower in S_SHWR, then lowers the live count once the tail is reached.
// The block takes one request at a time: req_tready is high only while the
// sequencer is idle, so a new request is not taken until the last has left S_DONE. A
// finished response sits in the output register while the next request is
// accepted; if the receiver holds rsp_tready low, the next response waits in
// the sequencer until the register is free.
// Reset clears the live count and the sequencer; memory contents are left
// as they are and are only used at live positions.
// Illegal indexes (at or above the live count) change nothing and return
// status 1; get then reads -1. Append into a full array returns status 2.
module packed_array_store (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [pas_pkg::REQ_W-1:0]  req_tdata,  // mode, index, value, zero pad
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [pas_pkg::RSP_W-1:0]  rsp_tdata   // read_value, status, count, zero pad
);
   import pas_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_GET  = 5'b00010,
      S_SHRD = 5'b00100,
      S_SHWR = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   live_count_ff, live_count_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [WORD_W-1:0]  res_rd_ff, res_rd_in;
   logic [STAT_W-1:0]  res_st_ff, res_st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [WORD_W-1:0]  mem [DEPTH];
   logic [WORD_W-1:0]  rd_data_ff;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [WORD_W-1:0]  mem_wdata;
   logic               mem_we;

   logic               req_fire;
   mode_type           req_mode;
   logic [IDX_W-1:0]   req_index;
   logic [WORD_W-1:0]  req_value;
   logic               idx_legal;
   logic               is_full;
   logic [CNT_W-1:0]   next_pos;
   logic               out_free;

   assign req_mode  = mode_type'(req_tdata[MODE_W-1:0]);
   assign req_index = req_tdata[MODE_W +: IDX_W];
   assign req_value = req_tdata[MODE_W + IDX_W +: WORD_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign idx_legal  = (CNT_W'(req_index) < live_count_ff);
   assign is_full    = (live_count_ff == CNT_W'(DEPTH));
   assign next_pos   = CNT_W'(ptr_ff) + CNT_W'(1);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      live_count_in = live_count_ff;
      ptr_in        = ptr_ff;
      res_rd_in     = res_rd_ff;
      res_st_in     = res_st_ff;
      mem_raddr     = req_index[ADDR_W-1:0];
      mem_waddr     = req_index[ADDR_W-1:0];
      mem_wdata     = req_value;
      mem_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_rd_in = '0;
               res_st_in = STAT_OK;
               state_in  = S_DONE;
               unique case (req_mode)
                  MODE_APPEND: begin
                     if (is_full) begin
                        res_st_in = STAT_FULL;
                     end else begin
                        mem_we        = 1'b1;
                        mem_waddr     = live_count_ff[ADDR_W-1:0];
                        live_count_in = live_count_ff + CNT_W'(1);
                     end
                  end
                  MODE_GET: begin
                     if (idx_legal) begin
                        state_in = S_GET;
                     end else begin
                        res_rd_in = READ_ILLEGAL;
                        res_st_in = STAT_ILLEGAL;
                     end
                  end
                  MODE_UPDATE: begin
                     if (idx_legal) begin
                        mem_we = 1'b1;
                     end else begin
                        res_st_in = STAT_ILLEGAL;
                     end
                  end
                  MODE_REMOVE: begin
                     if (idx_legal) begin
                        ptr_in   = req_index[ADDR_W-1:0];
                        state_in = S_SHRD;
                     end else begin
                        res_st_in = STAT_ILLEGAL;
                     end
                  end
                  default: begin
                     res_st_in = STAT_ILLEGAL;
                  end
               endcase
            end
         end
         S_GET: begin
            res_rd_in = rd_data_ff;
            state_in  = S_DONE;
         end
         S_SHRD: begin
            // fetch the element above the hole, or close the array when at the tail
            if (next_pos < live_count_ff) begin
               mem_raddr = next_pos[ADDR_W-1:0];
               state_in  = S_SHWR;
            end else begin
               live_count_in = live_count_ff - CNT_W'(1);
               state_in      = S_DONE;
            end
         end
         S_SHWR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = rd_data_ff;
            ptr_in    = next_pos[ADDR_W-1:0];
            state_in  = S_SHRD;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({live_count_ff, res_st_ff, res_rd_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         live_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_count_ff <= live_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      res_rd_ff   <= res_rd_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      live_count_ff <= CNT_W'(DEPTH))
      else $error("live count above depth");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the done step");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_mode == MODE_APPEND && !is_full)
      |=> live_count_ff == $past(live_count_ff) + CNT_W'(1))
      else $error("append did not grow the count");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHWR |-> next_pos < live_count_ff)
      else $error("shift step beyond the live elements");

   a_rsp_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_tready) |=> state_ff == S_DONE)
      else $error("response dropped while output busy");
`endif

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for the packed array store with a shadow array scoreboard
`timescale 1ns / 1ps

import pas_pkg::*;

typedef struct {
   logic [WORD_W-1:0] read_value;
   status_type        status;
   logic [CNT_W-1:0]  count;
} array_rsp_type;

// shadow copy of the array: predicts each response and checks it in order
class array_shadow_type;
   logic [WORD_W-1:0] words [DEPTH];
   int unsigned       live;
   array_rsp_type     pending [$];
   int unsigned       faults;

   function new();
      live   = 0;
      faults = 0;
      foreach (words[i]) words[i] = '0;
   endfunction

   function void note_request(mode_type mode, logic [IDX_W-1:0] idx,
                              logic [WORD_W-1:0] value);
      array_rsp_type exp_rsp;
      bit            legal;
      int unsigned   pos;
      legal              = idx < live;
      exp_rsp.read_value = '0;
      exp_rsp.status     = STAT_OK;
      case (mode)
         MODE_APPEND: begin
            if (live >= DEPTH) begin
               exp_rsp.status = STAT_FULL;
            end else begin
               words[live] = value;
               live++;
            end
         end
         MODE_GET: begin
            if (legal) begin
               exp_rsp.read_value = words[idx];
            end else begin
               exp_rsp.read_value = READ_ILLEGAL;
               exp_rsp.status     = STAT_ILLEGAL;
            end
         end
         MODE_UPDATE: begin
            if (legal) words[idx] = value;
            else exp_rsp.status = STAT_ILLEGAL;
         end
         default: begin
            if (legal) begin
               // close the gap, the old tail slot keeps its contents
               for (pos = idx; pos + 1 < live; pos++) words[pos] = words[pos + 1];
               live--;
            end else begin
               exp_rsp.status = STAT_ILLEGAL;
            end
         end
      endcase
      exp_rsp.count = CNT_W'(live);
      pending.push_back(exp_rsp);
   endfunction

   function void note_fault(string what, longint exp_v, longint got_v);
      faults++;
      if (faults <= 10) $display("%s: expected %0d, got %0d", what, exp_v, got_v);
   endfunction

   function void check_response(logic [RSP_W-1:0] tdata);
      array_rsp_type     exp_rsp;
      logic [WORD_W-1:0] got_value;
      logic [STAT_W-1:0] got_status;
      logic [CNT_W-1:0]  got_count;
      got_value  = tdata[WORD_W-1:0];
      got_status = tdata[WORD_W +: STAT_W];
      got_count  = tdata[WORD_W+STAT_W +: CNT_W];
      if (pending.size() == 0) begin
         note_fault("response with no request outstanding, pending count", 0, 1);
         return;
      end
      exp_rsp = pending.pop_front();
      if (got_value !== exp_rsp.read_value)
         note_fault("read_value", longint'($signed(exp_rsp.read_value)),
                    longint'($signed(got_value)));
      if (got_status !== exp_rsp.status)
         note_fault("status", longint'(exp_rsp.status), longint'(got_status));
      if (got_count !== exp_rsp.count)
         note_fault("count", longint'(exp_rsp.count), longint'(got_count));
   endfunction
endclass

module tb;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;   // mode, index, value, zero pad
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;   // read_value, status, count, zero pad

   array_shadow_type board;
   int               stall_left = 0;
   int               calm_left  = 0;

   packed_array_store i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [WORD_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // response side: check on handshake, then choose next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
      if (calm_left > 0) begin
         calm_left--;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(50, 200);
         else if ($urandom_range(0, 99) < 35) stall_left = pick_gap();
      end
   end

   task automatic send_request(int gap, mode_type mode, logic [IDX_W-1:0] idx,
                               logic [WORD_W-1:0] value);
      logic [REQ_W-1:0] word;
      word                          = '0;
      word[MODE_W-1:0]              = mode;
      word[MODE_W +: IDX_W]         = idx;
      word[MODE_W+IDX_W +: WORD_W]  = value;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      board.note_request(mode, idx, value);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int          target;
      int          retarget;
      int          sender_calm;
      int          gap;
      int          r;
      mode_type    mode;
      logic [IDX_W-1:0] idx;
      board       = new();
      target      = 0;
      retarget    = 0;
      sender_calm = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // illegal requests on an empty array
      send_request(pick_gap(), MODE_GET, 4'd0, 32'h1234_5678);
      send_request(pick_gap(), MODE_UPDATE, 4'd3, 32'hdead_beef);
      send_request(pick_gap(), MODE_REMOVE, 4'd15, 32'h0);
      // fill to the top with extreme words first
      send_request(pick_gap(), MODE_APPEND, 4'd0, 32'h8000_0000);
      send_request(pick_gap(), MODE_APPEND, 4'd15, 32'h7fff_ffff);
      send_request(pick_gap(), MODE_APPEND, 4'd0, 32'h0);
      send_request(pick_gap(), MODE_APPEND, 4'd0, 32'hffff_ffff);
      repeat (DEPTH - 4) send_request(pick_gap(), MODE_APPEND, 4'($urandom), $urandom);
      send_request(pick_gap(), MODE_APPEND, 4'd0, 32'h5555_aaaa);
      send_request(pick_gap(), MODE_GET, 4'd15, 32'h0);
      send_request(pick_gap(), MODE_GET, 4'd0, 32'hffff_ffff);
      send_request(pick_gap(), MODE_UPDATE, 4'd15, 32'h7fff_ffff);
      // longest shift, then the tail, then reads past the end
      send_request(pick_gap(), MODE_REMOVE, 4'd0, 32'h0);
      send_request(pick_gap(), MODE_REMOVE, 4'd14, 32'h0);
      send_request(pick_gap(), MODE_GET, 4'd15, 32'h0);
      send_request(pick_gap(), MODE_GET, 4'd14, 32'h0);
      send_request(pick_gap(), MODE_REMOVE, 4'd3, 32'h0);
      send_request(pick_gap(), MODE_UPDATE, 4'd14, 32'h0);
      wait_drained();

      for (int n = 0; n < 1822; n++) begin
         // wander the fill level, visiting empty and full often
         if (retarget == 0) begin
            r = $urandom_range(0, 99);
            if (r < 25) target = DEPTH;
            else if (r < 45) target = 0;
            else target = $urandom_range(1, DEPTH - 1);
            retarget = $urandom_range(40, 120);
         end
         retarget--;
         r = $urandom_range(0, 99);
         if (board.live < target)
            mode = r < 55 ? MODE_APPEND : r < 75 ? MODE_GET : r < 90 ? MODE_UPDATE : MODE_REMOVE;
         else if (board.live > target)
            mode = r < 45 ? MODE_REMOVE : r < 60 ? MODE_APPEND : r < 85 ? MODE_GET : MODE_UPDATE;
         else
            mode = mode_type'($urandom_range(0, 3));
         if (board.live != 0 && $urandom_range(0, 99) < 80)
            idx = IDX_W'($urandom_range(0, board.live - 1));
         else
            idx = IDX_W'($urandom_range(0, 15));
         if (sender_calm == 0 && $urandom_range(0, 99) < 2) sender_calm = $urandom_range(20, 60);
         if (sender_calm > 0) begin
            sender_calm--;
            gap = 0;
         end else begin
            gap = pick_gap();
         end
         send_request(gap, mode, idx, pick_value());
         if (n % 400 == 399) wait_drained();
      end

      wait_drained();
      repeat (80) @(posedge clock);
      if (board.faults == 0 && board.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
